/* rtl/mka_pkg.sv */
// Shared types, codes and constants for the menu key auto-repeat block.
`default_nettype none
package mka_pkg;

  localparam int BUTTON_W = 16;
  localparam int STICK_W  = 8;
  localparam int TIME_W   = 32;
  localparam int ACTION_W = 4;
  localparam int LEVEL_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Button bit positions
  localparam int BTN_SELECT = 0;
  localparam int BTN_START  = 3;
  localparam int BTN_UP     = 4;
  localparam int BTN_RIGHT  = 5;
  localparam int BTN_DOWN   = 6;
  localparam int BTN_LEFT   = 7;
  localparam int BTN_LTRIG  = 8;
  localparam int BTN_RTRIG  = 9;
  localparam int BTN_CIRCLE = 13;
  localparam int BTN_CROSS  = 14;
  localparam int BTN_SQUARE = 15;

  // Menu action codes
  localparam logic [ACTION_W-1:0] ACT_NONE      = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_LEFT      = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_RIGHT     = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_UP        = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_DOWN      = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_SELECT    = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_EXIT      = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_BACK      = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_RTRIG     = 4'd8;
  localparam logic [ACTION_W-1:0] ACT_LTRIG     = 4'd9;
  localparam logic [ACTION_W-1:0] ACT_SELECTKEY = 4'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

  // Stick threshold arithmetic
  localparam logic [STICK_W-1:0] STICK_BASE = 8'd92;
  localparam logic [STICK_W:0]   STICK_SPAN = 9'd256;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 5'd23;

  localparam logic [LEVEL_W-1:0] RST_LEVEL    = 5'd4;
  localparam logic [TIME_W-1:0]  RST_INITIAL  = 32'd200000;
  localparam logic [TIME_W-1:0]  RST_INTERVAL = 32'd50000;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_INITIAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  initial_us;
    logic [TIME_W-1:0]  interval_us;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/mka_in_if.sv */
// Input sample channel interface.
`default_nettype none
interface mka_in_if;
  logic                          valid;
  logic                          ready;
  logic [mka_pkg::BUTTON_W-1:0]  button_bits;
  logic                          hold_switch;
  logic [mka_pkg::STICK_W-1:0]   stick_x;
  logic [mka_pkg::STICK_W-1:0]   stick_y;
  logic [mka_pkg::TIME_W-1:0]    now_us;

  modport source (output valid, button_bits, hold_switch, stick_x, stick_y, now_us,
                  input ready);
  modport sink (input valid, button_bits, hold_switch, stick_x, stick_y, now_us,
                output ready);
endinterface
`default_nettype wire

/* rtl/mka_out_if.sv */
// Result channel interface.
`default_nettype none
interface mka_out_if;
  logic                          valid;
  logic                          ready;
  logic [mka_pkg::ACTION_W-1:0]  action;

  modport source (output valid, action, input ready);
  modport sink (input valid, action, output ready);
endinterface
`default_nettype wire

/* rtl/mka_cfg_if.sv */
// Configuration write channel interface.
`default_nettype none
interface mka_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mka_pkg::CFG_IDX_W-1:0]   index;
  logic [mka_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/mka_cfg_regs.sv */
// Configuration registers: stick level and repeat timing.
`default_nettype none
module mka_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst_n,
  mka_cfg_if.sink      cfg_ch,
  output mka_pkg::cfg_t cfg_o
);

  mka_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_ch.index)
        mka_pkg::CFG_LEVEL:    cfg_nxt.level       = cfg_ch.data[mka_pkg::LEVEL_W-1:0];
        mka_pkg::CFG_INITIAL:  cfg_nxt.initial_us  = cfg_ch.data;
        mka_pkg::CFG_INTERVAL: cfg_nxt.interval_us = cfg_ch.data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level       <= mka_pkg::RST_LEVEL;
      cfg_r.initial_us  <= mka_pkg::RST_INITIAL;
      cfg_r.interval_us <= mka_pkg::RST_INTERVAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule
`default_nettype wire

/* rtl/mka_stick_map.sv */
// Stick to direction mapping of the button word.
`default_nettype none
module mka_stick_map (
  input  wire logic [mka_pkg::LEVEL_W-1:0]  level_i,
  input  wire logic [mka_pkg::BUTTON_W-1:0] buttons_i,
  input  wire logic                         hold_i,
  input  wire logic [mka_pkg::STICK_W-1:0]  sx_i,
  input  wire logic [mka_pkg::STICK_W-1:0]  sy_i,
  output logic      [mka_pkg::BUTTON_W-1:0] buttons_o
);

  logic [mka_pkg::LEVEL_W-1:0] level_sat;
  logic [mka_pkg::STICK_W-1:0] lo;
  logic [mka_pkg::STICK_W:0]   hi;
  logic [mka_pkg::STICK_W:0]   sx_w, sy_w;

  assign level_sat = (level_i > mka_pkg::LEVEL_MAX) ? mka_pkg::LEVEL_MAX : level_i;
  assign lo   = mka_pkg::STICK_BASE - {1'b0, level_sat, 2'b00};
  assign hi   = mka_pkg::STICK_SPAN - {1'b0, lo};
  assign sx_w = {1'b0, sx_i};
  assign sy_w = {1'b0, sy_i};

  // Later checks override earlier ones: left, right, up, down
  always_comb begin
    buttons_o = buttons_i;
    if (!hold_i) begin
      if (sx_i < lo) buttons_o = mka_pkg::BUTTON_W'(1) << mka_pkg::BTN_LEFT;
      if (sx_w > hi) buttons_o = mka_pkg::BUTTON_W'(1) << mka_pkg::BTN_RIGHT;
      if (sy_i < lo) buttons_o = mka_pkg::BUTTON_W'(1) << mka_pkg::BTN_UP;
      if (sy_w > hi) buttons_o = mka_pkg::BUTTON_W'(1) << mka_pkg::BTN_DOWN;
    end
  end

endmodule
`default_nettype wire

/* rtl/mka_repeat_core.sv */
// Edge detection, action encoding and auto-repeat state.
`default_nettype none
module mka_repeat_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en_i,
  input  wire mka_pkg::cfg_t                cfg_i,
  input  wire logic [mka_pkg::BUTTON_W-1:0] buttons_i,
  input  wire logic [mka_pkg::TIME_W-1:0]   now_i,
  output logic      [mka_pkg::ACTION_W-1:0] action_o
);

  logic [mka_pkg::BUTTON_W-1:0] prev_r, prev_nxt;
  logic [mka_pkg::BUTTON_W-1:0] mask_r, mask_nxt;
  logic [mka_pkg::ACTION_W-1:0] ract_r, ract_nxt;
  logic [mka_pkg::TIME_W-1:0]   stamp_r, stamp_nxt;
  mka_pkg::phase_t              phase_r, phase_nxt;

  logic [mka_pkg::BUTTON_W-1:0] edges;
  logic [mka_pkg::ACTION_W-1:0] edge_act;
  logic [mka_pkg::TIME_W-1:0]   dt;
  logic                         held;

  assign edges = (prev_r ^ buttons_i) & buttons_i;
  assign held  = |(buttons_i & mask_r);
  assign dt    = now_i - stamp_r;

  // Last matching code wins
  always_comb begin
    edge_act = mka_pkg::ACT_NONE;
    if (edges[mka_pkg::BTN_LEFT])   edge_act = mka_pkg::ACT_LEFT;
    if (edges[mka_pkg::BTN_RIGHT])  edge_act = mka_pkg::ACT_RIGHT;
    if (edges[mka_pkg::BTN_UP])     edge_act = mka_pkg::ACT_UP;
    if (edges[mka_pkg::BTN_DOWN])   edge_act = mka_pkg::ACT_DOWN;
    if (edges[mka_pkg::BTN_START])  edge_act = mka_pkg::ACT_SELECT;
    if (edges[mka_pkg::BTN_CIRCLE]) edge_act = mka_pkg::ACT_SELECT;
    if (edges[mka_pkg::BTN_CROSS])  edge_act = mka_pkg::ACT_EXIT;
    if (edges[mka_pkg::BTN_SQUARE]) edge_act = mka_pkg::ACT_BACK;
    if (edges[mka_pkg::BTN_RTRIG])  edge_act = mka_pkg::ACT_RTRIG;
    if (edges[mka_pkg::BTN_LTRIG])  edge_act = mka_pkg::ACT_LTRIG;
    if (edges[mka_pkg::BTN_SELECT]) edge_act = mka_pkg::ACT_SELECTKEY;
  end

  always_comb begin
    prev_nxt  = buttons_i;
    mask_nxt  = mask_r;
    ract_nxt  = ract_r;
    stamp_nxt = stamp_r;
    phase_nxt = phase_r;
    action_o  = edge_act;
    if (edge_act != mka_pkg::ACT_NONE) begin
      // arm the repeat for the new action
      stamp_nxt = now_i;
      phase_nxt = mka_pkg::PH_INITIAL;
      mask_nxt  = edges;
      ract_nxt  = edge_act;
    end else if (held) begin
      unique case (phase_r)
        mka_pkg::PH_INITIAL: begin
          if (dt > cfg_i.initial_us) begin
            action_o  = ract_r;
            stamp_nxt = now_i;
            phase_nxt = mka_pkg::PH_REPEAT;
          end
        end
        mka_pkg::PH_REPEAT: begin
          if (dt > cfg_i.interval_us) begin
            action_o  = ract_r;
            stamp_nxt = now_i;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      mask_r  <= '0;
      ract_r  <= mka_pkg::ACT_NONE;
      stamp_r <= '0;
      phase_r <= mka_pkg::PH_IDLE;
    end else if (en_i) begin
      prev_r  <= prev_nxt;
      mask_r  <= mask_nxt;
      ract_r  <= ract_nxt;
      stamp_r <= stamp_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/menu_key_autorepeat.sv */
// Menu key auto-repeat: turns controller poll samples into menu actions.
//
// in_ch carries one poll sample per transaction: button word, hold switch,
// stick X/Y and a microsecond timestamp. out_ch returns exactly one action
// code per sample, in order (0 means no action). cfg_ch writes the stick
// sensitivity level and the initial and interval repeat times; it is always
// ready and should be used only while no sample is in flight.
//
// A sample is registered on acceptance, then evaluated in one pass against
// the repeat state; its action is loaded into the result register once
// that register is free or being taken. One sample per cycle is sustained
// while out_ch is ready; the single evaluation stage sets that rate.
//
// Reset clears the edge history and the repeat state and loads the default
// configuration. When out_ch stalls, the result holds in the output
// register and one more sample waits in the input register; in_ch.ready
// then drops until the result is taken.
`default_nettype none
module menu_key_autorepeat (
  input  wire logic clk,
  input  wire logic rst_n,
  mka_in_if.sink    in_ch,
  mka_out_if.source out_ch,
  mka_cfg_if.sink   cfg_ch
);

  mka_pkg::cfg_t                cfg;
  logic                         s_valid_r, s_valid_nxt;
  logic [mka_pkg::BUTTON_W-1:0] s_buttons_r;
  logic                         s_hold_r;
  logic [mka_pkg::STICK_W-1:0]  s_sx_r, s_sy_r;
  logic [mka_pkg::TIME_W-1:0]   s_now_r;
  logic                         o_valid_r, o_valid_nxt;
  logic [mka_pkg::ACTION_W-1:0] o_action_r;
  logic [mka_pkg::BUTTON_W-1:0] mapped;
  logic [mka_pkg::ACTION_W-1:0] action;
  logic                         adv;
  logic                         in_acc;

  mka_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  // Advance the staged sample when the result register is free
  assign adv         = s_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready = !s_valid_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_acc)   s_valid_nxt = 1'b1;
    else if (adv) s_valid_nxt = 1'b0;
    o_valid_nxt = o_valid_r;
    if (adv)               o_valid_nxt = 1'b1;
    else if (out_ch.ready) o_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_buttons_r <= in_ch.button_bits;
      s_hold_r    <= in_ch.hold_switch;
      s_sx_r      <= in_ch.stick_x;
      s_sy_r      <= in_ch.stick_y;
      s_now_r     <= in_ch.now_us;
    end
    if (adv) begin
      o_action_r <= action;
    end
  end

  mka_stick_map u_map (
    .level_i   (cfg.level),
    .buttons_i (s_buttons_r),
    .hold_i    (s_hold_r),
    .sx_i      (s_sx_r),
    .sy_i      (s_sy_r),
    .buttons_o (mapped)
  );

  mka_repeat_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en_i      (adv),
    .cfg_i     (cfg),
    .buttons_i (mapped),
    .now_i     (s_now_r),
    .action_o  (action)
  );

  assign out_ch.valid  = o_valid_r;
  assign out_ch.action = o_action_r;

endmodule
`default_nettype wire
